/* design/pitm_pkg.sv */
// Shared types, widths and codes of the point-in-triangle mesh test.
package pitm_pkg;

   localparam int CW        = 16;            // coordinate width, Q4.12
   localparam int MAX_TRI   = 64;            // triangle table depth
   localparam int SLOT_W    = 6;             // table address width
   localparam int CNT_W     = 7;             // triangle count register width
   localparam int TOL_W     = 25;            // area tolerance width
   localparam int SQ_W      = 2 * CW + 1;    // squared side length, Q.24
   localparam int LEN_W     = CW + 1;        // side length, Q.12
   localparam int SUM_W     = LEN_W + 2;     // perimeter sum, Q.12
   localparam int T_W       = SUM_W + 2;     // signed s - 2*l
   localparam int MUL_W     = SUM_W;         // multiplier operand width
   localparam int HALF_W    = MUL_W;         // partial product split point
   localparam int PROD_W    = 2 * MUL_W;     // multiplier product width
   localparam int RAD_W     = 2 * PROD_W;    // Heron product, Q.48
   localparam int ROOT_W    = PROD_W;        // root of the Heron product
   localparam int AREA_W    = ROOT_W - 2;    // area, Q12.24
   localparam int EXC_W     = AREA_W + 4;    // signed area excess
   localparam int ITER_W    = 6;             // square root step counter
   localparam int SIDE_N    = 6;             // side lengths per triangle

   localparam logic [CNT_W-1:0] TRI_COUNT_RESET = CNT_W'(44);
   localparam logic [TOL_W-1:0] TOL_RESET       = TOL_W'(83886);

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // register indexes
   localparam logic CSR_TRIANGLE_COUNT = 1'b0;
   localparam logic CSR_AREA_TOLERANCE = 1'b1;

   // side indexes
   localparam logic [2:0] SIDE_AB = 3'd0;
   localparam logic [2:0] SIDE_BC = 3'd1;
   localparam logic [2:0] SIDE_AC = 3'd2;
   localparam logic [2:0] SIDE_AP = 3'd3;
   localparam logic [2:0] SIDE_BP = 3'd4;
   localparam logic [2:0] SIDE_CP = 3'd5;

   // Heron area indexes
   localparam logic [1:0] HERON_ABP = 2'd0;
   localparam logic [1:0] HERON_BCP = 2'd1;
   localparam logic [1:0] HERON_ACP = 2'd2;
   localparam logic [1:0] HERON_ABC = 2'd3;

   typedef struct packed {
      logic signed [CW-1:0] z;
      logic signed [CW-1:0] x;
   } point_type;

   typedef struct packed {
      point_type c;
      point_type b;
      point_type a;
   } tri_type;

   typedef struct packed {
      logic start;
      logic short_mode;
   } sqrt_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SIDE_X,
      ST_SIDE_Z,
      ST_SIDE_SQ,
      ST_SIDE_WAIT,
      ST_HERON_PREP,
      ST_HERON_M1,
      ST_HERON_M2,
      ST_HERON_M3,
      ST_HERON_PP,
      ST_HERON_SQ,
      ST_HERON_WAIT,
      ST_HERON_ACC,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

/* design/pitm_if.sv */
// Request, response and register write channels.
interface pitm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [pitm_pkg::SLOT_W-1:0] tri_slot;
   logic signed [pitm_pkg::CW-1:0] ax;
   logic signed [pitm_pkg::CW-1:0] az;
   logic signed [pitm_pkg::CW-1:0] bx;
   logic signed [pitm_pkg::CW-1:0] bz;
   logic signed [pitm_pkg::CW-1:0] cx;
   logic signed [pitm_pkg::CW-1:0] cz;
   logic signed [pitm_pkg::CW-1:0] point_x;
   logic signed [pitm_pkg::CW-1:0] point_z;

   modport source (output valid, req_type, tri_slot, ax, az, bx, bz, cx, cz,
                   point_x, point_z, input ready);
   modport sink (input valid, req_type, tri_slot, ax, az, bx, bz, cx, cz,
                 point_x, point_z, output ready);
endinterface

interface pitm_rsp_if;
   logic valid;
   logic ready;
   logic on_track;

   modport source (output valid, on_track, input ready);
   modport sink (input valid, on_track, output ready);
endinterface

interface pitm_csr_if;
   logic                        valid;
   logic                        ready;
   logic                        index;
   logic [pitm_pkg::TOL_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/point_in_triangle_mesh_test.sv */
// Top level: triangle table, query sequencer and shared arithmetic units.
// A load writes the table and returns nothing; a query answers once every triangle
// up to N = min(triangle_count, 64) has been tested, with no triangle tested when N is 0.
// Per triangle the shared square root sets the time: six side roots of 17
// root bits and four Heron roots of 38 bits, fewer when a Heron factor is negative; one request is in work at a time.
// Synchronous active-high reset: idle, count 44, tolerance 83886; table undefined.
module point_in_triangle_mesh_test (
   input  logic       clock,
   input  logic       reset,
   pitm_req_if.sink   req_ch,
   pitm_rsp_if.source rsp_ch,
   pitm_csr_if.sink   csr_ch
);

   // Control and configuration state
   pitm_pkg::state_type           state_ff, state_in;
   logic [pitm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [pitm_pkg::TOL_W-1:0]    tol_ff, tol_in;
   logic [pitm_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [pitm_pkg::CNT_W-1:0]    n_ff, n_in;
   logic [2:0]                    side_ff, side_in;
   logic [1:0]                    heron_ff, heron_in;
   logic [2:0]                    pp_cnt_ff, pp_cnt_in;
   logic                          hit_ff, hit_in;

   // Datapath registers
   pitm_pkg::point_type           p_ff, p_in;
   logic [pitm_pkg::SQ_W-1:0]     sq_ff, sq_in;
   logic [pitm_pkg::LEN_W-1:0]    len_ff [pitm_pkg::SIDE_N];
   logic [pitm_pkg::LEN_W-1:0]    len_in;
   logic                          len_we;
   logic [pitm_pkg::SUM_W-1:0]    s_ff, s_in;
   logic [pitm_pkg::SUM_W-1:0]    t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [pitm_pkg::PROD_W-1:0]   u_ff, u_in, v_ff, v_in;
   logic [pitm_pkg::RAD_W-1:0]    acc_ff, acc_in;
   logic [pitm_pkg::AREA_W-1:0]   area_ff, area_in;
   logic signed [pitm_pkg::EXC_W-1:0] excess_ff, excess_in;

   // Unit connections
   pitm_pkg::tri_type             tri_q;
   pitm_pkg::tri_type             tri_wr;
   logic                          store_we;
   logic [pitm_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic [pitm_pkg::PROD_W-1:0]   mul_prod;
   pitm_pkg::sqrt_ctl_type        sqrt_ctl;
   logic [pitm_pkg::RAD_W-1:0]    sqrt_rad;
   logic                          sqrt_done;
   logic [pitm_pkg::ROOT_W-1:0]   sqrt_root;

   // Combinational helpers
   logic                          req_fire, rsp_fire;
   pitm_pkg::point_type           pa, pb;
   logic signed [pitm_pkg::CW:0]  diff_x, diff_z;
   logic [pitm_pkg::CW-1:0]       dx, dz;
   logic [pitm_pkg::SQ_W-1:0]     sq_sum;
   logic [pitm_pkg::LEN_W-1:0]    l1, l2, l3;
   logic [pitm_pkg::SUM_W-1:0]    s_sum;
   logic [pitm_pkg::T_W-1:0]      t1w, t2w, t3w;
   logic                          heron_neg;
   logic                          last_tri;
   logic signed [pitm_pkg::EXC_W-1:0] tol_ext;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // Table, multiplier and square root
   assign tri_wr.a.x = req_ch.ax;
   assign tri_wr.a.z = req_ch.az;
   assign tri_wr.b.x = req_ch.bx;
   assign tri_wr.b.z = req_ch.bz;
   assign tri_wr.c.x = req_ch.cx;
   assign tri_wr.c.z = req_ch.cz;

   pitm_store u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (req_ch.tri_slot),
      .wr_data (tri_wr),
      .rd_addr (idx_ff[pitm_pkg::SLOT_W-1:0]),
      .rd_data (tri_q)
   );

   pitm_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   pitm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sqrt_ctl),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Pick the two endpoints of the side in work
   always_comb begin
      case (side_ff)
         pitm_pkg::SIDE_AB: begin pa = tri_q.a; pb = tri_q.b; end
         pitm_pkg::SIDE_BC: begin pa = tri_q.b; pb = tri_q.c; end
         pitm_pkg::SIDE_AC: begin pa = tri_q.a; pb = tri_q.c; end
         pitm_pkg::SIDE_AP: begin pa = tri_q.a; pb = p_ff;    end
         pitm_pkg::SIDE_BP: begin pa = tri_q.b; pb = p_ff;    end
         default:           begin pa = tri_q.c; pb = p_ff;    end
      endcase
      diff_x = $signed({pa.x[pitm_pkg::CW-1], pa.x}) - $signed({pb.x[pitm_pkg::CW-1], pb.x});
      diff_z = $signed({pa.z[pitm_pkg::CW-1], pa.z}) - $signed({pb.z[pitm_pkg::CW-1], pb.z});
      dx = diff_x[pitm_pkg::CW] ? pitm_pkg::CW'(-diff_x) : diff_x[pitm_pkg::CW-1:0];
      dz = diff_z[pitm_pkg::CW] ? pitm_pkg::CW'(-diff_z) : diff_z[pitm_pkg::CW-1:0];
      sq_sum = sq_ff + pitm_pkg::SQ_W'(mul_prod);
   end

   // Pick the three sides of the Heron area in work; the result is symmetric
   always_comb begin
      case (heron_ff)
         pitm_pkg::HERON_ABP: begin
            l1 = len_ff[pitm_pkg::SIDE_AB]; l2 = len_ff[pitm_pkg::SIDE_AP];
            l3 = len_ff[pitm_pkg::SIDE_BP];
         end
         pitm_pkg::HERON_BCP: begin
            l1 = len_ff[pitm_pkg::SIDE_BC]; l2 = len_ff[pitm_pkg::SIDE_BP];
            l3 = len_ff[pitm_pkg::SIDE_CP];
         end
         pitm_pkg::HERON_ACP: begin
            l1 = len_ff[pitm_pkg::SIDE_AC]; l2 = len_ff[pitm_pkg::SIDE_AP];
            l3 = len_ff[pitm_pkg::SIDE_CP];
         end
         default: begin
            l1 = len_ff[pitm_pkg::SIDE_AB]; l2 = len_ff[pitm_pkg::SIDE_BC];
            l3 = len_ff[pitm_pkg::SIDE_AC];
         end
      endcase
      s_sum = pitm_pkg::SUM_W'(l1) + pitm_pkg::SUM_W'(l2) + pitm_pkg::SUM_W'(l3);
      t1w = pitm_pkg::T_W'(s_sum) - pitm_pkg::T_W'({l1, 1'b0});
      t2w = pitm_pkg::T_W'(s_sum) - pitm_pkg::T_W'({l2, 1'b0});
      t3w = pitm_pkg::T_W'(s_sum) - pitm_pkg::T_W'({l3, 1'b0});
      // a negative Heron factor clamps the area to zero
      heron_neg = t1w[pitm_pkg::T_W-1] || t2w[pitm_pkg::T_W-1] || t3w[pitm_pkg::T_W-1];
   end

   assign last_tri = (idx_ff + 1'b1) == n_ff;
   assign tol_ext  = $signed(pitm_pkg::EXC_W'(tol_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pitm_pkg::ST_IDLE: begin
            if (req_fire && req_ch.req_type == pitm_pkg::REQ_QUERY) begin
               if (count_ff == '0) begin
                  state_in = pitm_pkg::ST_DONE;
               end else begin
                  state_in = pitm_pkg::ST_READ;
               end
            end
         end
         pitm_pkg::ST_READ:      state_in = pitm_pkg::ST_SIDE_X;
         pitm_pkg::ST_SIDE_X:    state_in = pitm_pkg::ST_SIDE_Z;
         pitm_pkg::ST_SIDE_Z:    state_in = pitm_pkg::ST_SIDE_SQ;
         pitm_pkg::ST_SIDE_SQ:   state_in = pitm_pkg::ST_SIDE_WAIT;
         pitm_pkg::ST_SIDE_WAIT: begin
            if (sqrt_done) begin
               state_in = (side_ff == pitm_pkg::SIDE_CP) ? pitm_pkg::ST_HERON_PREP
                                                          : pitm_pkg::ST_SIDE_X;
            end
         end
         pitm_pkg::ST_HERON_PREP: begin
            state_in = heron_neg ? pitm_pkg::ST_HERON_ACC : pitm_pkg::ST_HERON_M1;
         end
         pitm_pkg::ST_HERON_M1:  state_in = pitm_pkg::ST_HERON_M2;
         pitm_pkg::ST_HERON_M2:  state_in = pitm_pkg::ST_HERON_M3;
         pitm_pkg::ST_HERON_M3:  state_in = pitm_pkg::ST_HERON_PP;
         pitm_pkg::ST_HERON_PP: begin
            if (pp_cnt_ff == 3'd4) begin
               state_in = pitm_pkg::ST_HERON_SQ;
            end
         end
         pitm_pkg::ST_HERON_SQ:  state_in = pitm_pkg::ST_HERON_WAIT;
         pitm_pkg::ST_HERON_WAIT: begin
            if (sqrt_done) begin
               state_in = pitm_pkg::ST_HERON_ACC;
            end
         end
         pitm_pkg::ST_HERON_ACC: begin
            state_in = (heron_ff == pitm_pkg::HERON_ABC) ? pitm_pkg::ST_NEXT
                                                         : pitm_pkg::ST_HERON_PREP;
         end
         pitm_pkg::ST_NEXT: begin
            state_in = last_tri ? pitm_pkg::ST_DONE : pitm_pkg::ST_READ;
         end
         pitm_pkg::ST_DONE: begin
            if (rsp_fire) begin
               state_in = pitm_pkg::ST_IDLE;
            end
         end
         default: state_in = pitm_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshakes and unit operands
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      store_we     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      sqrt_ctl     = '0;
      sqrt_rad     = '0;
      unique case (state_ff)
         pitm_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            store_we     = req_ch.valid && req_ch.req_type == pitm_pkg::REQ_LOAD;
         end
         pitm_pkg::ST_SIDE_X: begin
            mul_a = pitm_pkg::MUL_W'(dx);
            mul_b = pitm_pkg::MUL_W'(dx);
         end
         pitm_pkg::ST_SIDE_Z: begin
            mul_a = pitm_pkg::MUL_W'(dz);
            mul_b = pitm_pkg::MUL_W'(dz);
         end
         pitm_pkg::ST_SIDE_SQ: begin
            sqrt_ctl.start      = 1'b1;
            sqrt_ctl.short_mode = 1'b1;
            sqrt_rad            = pitm_pkg::RAD_W'(sq_sum);
         end
         pitm_pkg::ST_HERON_M1: begin
            mul_a = s_ff;
            mul_b = t1_ff;
         end
         pitm_pkg::ST_HERON_M2: begin
            mul_a = t2_ff;
            mul_b = t3_ff;
         end
         pitm_pkg::ST_HERON_PP: begin
            // four partial products of the 38 by 38 bit Heron product
            case (pp_cnt_ff)
               3'd0: begin
                  mul_a = u_ff[pitm_pkg::HALF_W-1:0];
                  mul_b = v_ff[pitm_pkg::HALF_W-1:0];
               end
               3'd1: begin
                  mul_a = u_ff[pitm_pkg::HALF_W-1:0];
                  mul_b = v_ff[pitm_pkg::PROD_W-1:pitm_pkg::HALF_W];
               end
               3'd2: begin
                  mul_a = u_ff[pitm_pkg::PROD_W-1:pitm_pkg::HALF_W];
                  mul_b = v_ff[pitm_pkg::HALF_W-1:0];
               end
               3'd3: begin
                  mul_a = u_ff[pitm_pkg::PROD_W-1:pitm_pkg::HALF_W];
                  mul_b = v_ff[pitm_pkg::PROD_W-1:pitm_pkg::HALF_W];
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         pitm_pkg::ST_HERON_SQ: begin
            sqrt_ctl.start = 1'b1;
            sqrt_rad       = acc_ff;
         end
         pitm_pkg::ST_DONE: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.on_track = hit_ff;
   assign csr_ch.ready    = 1'b1;

   // Datapath and counter updates
   always_comb begin
      count_in  = count_ff;
      tol_in    = tol_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      side_in   = side_ff;
      heron_in  = heron_ff;
      pp_cnt_in = pp_cnt_ff;
      hit_in    = hit_ff;
      p_in      = p_ff;
      sq_in     = sq_ff;
      len_in    = sqrt_root[pitm_pkg::LEN_W-1:0];
      len_we    = 1'b0;
      s_in      = s_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      t3_in     = t3_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      acc_in    = acc_ff;
      area_in   = area_ff;
      excess_in = excess_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            pitm_pkg::CSR_TRIANGLE_COUNT: count_in = csr_ch.data[pitm_pkg::CNT_W-1:0];
            pitm_pkg::CSR_AREA_TOLERANCE: tol_in   = csr_ch.data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         pitm_pkg::ST_IDLE: begin
            // hold the point, clamp the count to the table depth
            p_in.x = req_ch.point_x;
            p_in.z = req_ch.point_z;
            n_in   = (count_ff > pitm_pkg::CNT_W'(pitm_pkg::MAX_TRI))
                     ? pitm_pkg::CNT_W'(pitm_pkg::MAX_TRI) : count_ff;
            idx_in = '0;
            hit_in = 1'b0;
         end
         pitm_pkg::ST_READ: begin
            side_in   = pitm_pkg::SIDE_AB;
            excess_in = '0;
         end
         pitm_pkg::ST_SIDE_Z: begin
            sq_in = pitm_pkg::SQ_W'(mul_prod);
         end
         pitm_pkg::ST_SIDE_WAIT: begin
            if (sqrt_done) begin
               len_we   = 1'b1;
               side_in  = side_ff + 1'b1;
               heron_in = pitm_pkg::HERON_ABP;
            end
         end
         pitm_pkg::ST_HERON_PREP: begin
            s_in    = s_sum;
            t1_in   = t1w[pitm_pkg::SUM_W-1:0];
            t2_in   = t2w[pitm_pkg::SUM_W-1:0];
            t3_in   = t3w[pitm_pkg::SUM_W-1:0];
            area_in = '0;
         end
         pitm_pkg::ST_HERON_M2: begin
            u_in = mul_prod;
         end
         pitm_pkg::ST_HERON_M3: begin
            v_in      = mul_prod;
            acc_in    = '0;
            pp_cnt_in = '0;
         end
         pitm_pkg::ST_HERON_PP: begin
            // accumulate the partial product issued in the previous cycle
            pp_cnt_in = pp_cnt_ff + 1'b1;
            case (pp_cnt_ff) inside
               3'd1:       acc_in = acc_ff + pitm_pkg::RAD_W'(mul_prod);
               3'd2, 3'd3: acc_in = acc_ff + (pitm_pkg::RAD_W'(mul_prod) << pitm_pkg::HALF_W);
               3'd4:       acc_in = acc_ff
                                    + (pitm_pkg::RAD_W'(mul_prod) << (2 * pitm_pkg::HALF_W));
               default:    acc_in = acc_ff;
            endcase
         end
         pitm_pkg::ST_HERON_WAIT: begin
            if (sqrt_done) begin
               area_in = sqrt_root[pitm_pkg::ROOT_W-1:2];
            end
         end
         pitm_pkg::ST_HERON_ACC: begin
            // add the three point areas, drop the triangle's own area
            if (heron_ff == pitm_pkg::HERON_ABC) begin
               excess_in = excess_ff - $signed(pitm_pkg::EXC_W'(area_ff));
            end else begin
               excess_in = excess_ff + $signed(pitm_pkg::EXC_W'(area_ff));
            end
            heron_in = heron_ff + 1'b1;
         end
         pitm_pkg::ST_NEXT: begin
            if (excess_ff <= tol_ext) begin
               hit_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pitm_pkg::ST_IDLE;
         count_ff  <= pitm_pkg::TRI_COUNT_RESET;
         tol_ff    <= pitm_pkg::TOL_RESET;
         idx_ff    <= '0;
         n_ff      <= '0;
         side_ff   <= '0;
         heron_ff  <= '0;
         pp_cnt_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         tol_ff    <= tol_in;
         idx_ff    <= idx_in;
         n_ff      <= n_in;
         side_ff   <= side_in;
         heron_ff  <= heron_in;
         pp_cnt_ff <= pp_cnt_in;
         hit_ff    <= hit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      sq_ff     <= sq_in;
      s_ff      <= s_in;
      t1_ff     <= t1_in;
      t2_ff     <= t2_in;
      t3_ff     <= t3_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      acc_ff    <= acc_in;
      area_ff   <= area_in;
      excess_ff <= excess_in;
      if (len_we) begin
         len_ff[side_ff] <= len_in;
      end
   end

endmodule

/* design/pitm_store.sv */
// Triangle table: one write port, one registered read port.
module pitm_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [pitm_pkg::SLOT_W-1:0] wr_addr,
   input  pitm_pkg::tri_type           wr_data,
   input  logic [pitm_pkg::SLOT_W-1:0] rd_addr,
   output pitm_pkg::tri_type           rd_data
);

   pitm_pkg::tri_type mem_ff [pitm_pkg::MAX_TRI];
   pitm_pkg::tri_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pitm_mul.sv */
// Shared unsigned multiplier with a registered product.
module pitm_mul (
   input  logic                        clock,
   input  logic [pitm_pkg::MUL_W-1:0]  op_a,
   input  logic [pitm_pkg::MUL_W-1:0]  op_b,
   output logic [pitm_pkg::PROD_W-1:0] prod
);

   logic [pitm_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

/* design/pitm_sqrt.sv */
// Shared integer square root, one root bit per cycle.
module pitm_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  pitm_pkg::sqrt_ctl_type      ctl,
   input  logic [pitm_pkg::RAD_W-1:0]  radicand,
   output logic                        done,
   output logic [pitm_pkg::ROOT_W-1:0] root
);

   localparam int REM_W = pitm_pkg::ROOT_W + 2;
   localparam int PRE_SHIFT = 2 * (pitm_pkg::ROOT_W - pitm_pkg::LEN_W);

   logic [pitm_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [pitm_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [pitm_pkg::ITER_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [REM_W-1:0]            rem_sh;
   logic [REM_W-1:0]            trial;

   always_comb begin
      rem_sh  = {rem_ff[pitm_pkg::ROOT_W-1:0], rad_ff[pitm_pkg::RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         // align a short radicand so its top pair enters first
         rad_in  = ctl.short_mode ? (radicand << PRE_SHIFT) : radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = ctl.short_mode ? pitm_pkg::ITER_W'(pitm_pkg::LEN_W)
                                  : pitm_pkg::ITER_W'(pitm_pkg::ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[pitm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[pitm_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pitm_pkg::ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
